// ----- design/qlss_pkg.sv -----
// ----------------------------------------------------------------------------
// qlss_pkg
// Shared types, constants and helper functions of the quad line set selector.
// ----------------------------------------------------------------------------
package qlss_pkg;

    // fixed field widths
    localparam int COORD_W   = 16;   // line endpoint coordinate
    localparam int DIM_W     = 12;   // image width / height register
    localparam int IDX_OUT_W = 16;   // reported set index
    localparam int SCORE_W   = 32;   // reported score
    localparam int NUM_LINES = 4;    // lines per set
    localparam int NUM_PAIRS = 6;    // line pairs (and corner pairs) per set

    // intermediate widths of the intersection math
    localparam int DL_W = COORD_W + 1;        // line direction component
    localparam int CL_W = 2 * COORD_W + 1;    // line cross term
    localparam int D_W  = 2 * DL_W;           // determinant, signed
    localparam int NX_W = CL_W + DL_W - 1;    // intersection numerator, signed
    localparam int MA_W = D_W;                // multiplier operand A

    // parameter defaults
    localparam int DEF_SET_INDEX_BITS = 16;
    localparam int DEF_FRACTION_BITS  = 8;

    // register map
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd720;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd160;

    // shared unit operation
    typedef enum logic {
        OP_DIV  = 1'b0,
        OP_SQRT = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

    // pair p -> first member
    function automatic logic [1:0] pair_first(input logic [2:0] p);
        logic [1:0] r;
        case (p)
            3'd0, 3'd1, 3'd2: r = 2'd0;
            3'd3, 3'd4:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // pair p -> second member
    function automatic logic [1:0] pair_second(input logic [2:0] p);
        logic [1:0] r;
        case (p)
            3'd0:       r = 2'd1;
            3'd1, 3'd3: r = 2'd2;
            default:    r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

// ----- design/qlss_mul.sv -----
// ----------------------------------------------------------------------------
// qlss_mul
// Signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module qlss_mul
    import qlss_pkg::*;
#(
    parameter int AW = MA_W,
    parameter int BW = 22
)
(
    input  logic                    clk,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    logic signed [AW+BW-1:0] p_reg;

    // one product per cycle
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ----- design/qlss_iter_unit.sv -----
// ----------------------------------------------------------------------------
// qlss_iter_unit
// Shared restoring divide / square-root unit, one result bit per cycle.
// ----------------------------------------------------------------------------
module qlss_iter_unit
    import qlss_pkg::*;
#(
    parameter int UW       = 56,
    parameter int DIV_BITS = 20,
    parameter int SQ_BITS  = 21
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  unit_ctl_t        ctl,
    input  logic [UW-1:0]    a,      // dividend or radicand
    input  logic [D_W-2:0]   b,      // divisor
    output unit_sts_t        sts,
    output logic [UW-1:0]    result
);

    localparam int CW = $clog2(SQ_BITS + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    unit_op_t      op_reg;
    logic [UW-1:0] acc_reg;
    logic [UW-1:0] opd_reg;
    logic [UW-1:0] res_reg;

    logic [UW-1:0] sub_b;
    logic [UW-1:0] diff;
    logic          ge;

    // the single shared compare / subtract
    assign sub_b = (op_reg == OP_SQRT) ? (res_reg + opd_reg) : opd_reg;
    assign ge    = (acc_reg >= sub_b);
    assign diff  = acc_reg - sub_b;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_DIV;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctl.op;
                cnt_reg  <= (ctl.op == OP_SQRT) ? CW'(SQ_BITS) : CW'(DIV_BITS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctl.start && !busy_reg)
        begin
            acc_reg <= a;
            res_reg <= '0;
            if (ctl.op == OP_SQRT)
                opd_reg <= UW'(1) << (2 * (SQ_BITS - 1));
            else
                opd_reg <= UW'(b) << (DIV_BITS - 1);
        end
        else if (busy_reg)
        begin
            if (ge)
                acc_reg <= diff;
            if (op_reg == OP_SQRT)
            begin
                res_reg <= ge ? ((res_reg >> 1) + opd_reg) : (res_reg >> 1);
                opd_reg <= opd_reg >> 2;
            end
            else
            begin
                res_reg <= {res_reg[UW-2:0], ge};
                opd_reg <= opd_reg >> 1;
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = res_reg;

endmodule

// ----- design/quad_line_set_selector.sv -----
// ----------------------------------------------------------------------------
// quad_line_set_selector
// Picks the set of four lines whose in-image corners lie farthest apart.
// ----------------------------------------------------------------------------
// Lines arrive one per item; every fourth line closes a set. The first three
// lines of a set are only stored. The fourth starts a sequencer that forms
// the line cross terms, intersects the six line pairs on one multiplier,
// converts each kept corner with two divisions on the shared
// divide/square-root unit, and, with exactly four corners, sums six
// distances, each through a square root on that unit. The item flagged tlast
// yields one result: best set index, its score, and tuser = found. The input
// is not ready while a set is worked.
module quad_line_set_selector
    import qlss_pkg::*;
#(
    parameter int SET_INDEX_BITS = DEF_SET_INDEX_BITS,
    parameter int FRACTION_BITS  = DEF_FRACTION_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    // line items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // start_x, start_y, end_x, end_y
    input  logic        s_tlast,   // last_of_all
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // best_index, best_score
    output logic        m_tuser,   // found
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int FIX_W = DIM_W + FRACTION_BITS;       // corner coordinate
    localparam int MB_W  = FIX_W + 2;                   // multiplier operand B
    localparam int PW    = MA_W + MB_W;                 // product width
    localparam int UW    = NX_W - 1 + FRACTION_BITS;    // shared unit width
    localparam int DIV_BITS = FIX_W;
    localparam int SQ_BITS  = FIX_W + 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_COEF   = 6'b000010,
        ST_PAIR   = 6'b000100,
        ST_DIST   = 6'b001000,
        ST_REPORT = 6'b010000,
        ST_SPARE  = 6'b100000
    } state_t;

    // control state
    state_t                    state_reg;
    logic [3:0]                step_reg;
    logic [2:0]                idx_reg;
    logic [1:0]                pos_reg;
    logic [2:0]                n_reg;
    logic [SET_INDEX_BITS-1:0] set_count_reg;
    logic [SET_INDEX_BITS-1:0] top_index_reg;
    logic [SCORE_W-1:0]        top_score_reg;
    logic                      any_found_reg;
    logic                      out_valid_reg;
    logic [DIM_W-1:0]          width_reg;
    logic [DIM_W-1:0]          height_reg;

    // payload
    logic signed [COORD_W-1:0] lx0_reg [NUM_LINES];
    logic signed [COORD_W-1:0] ly0_reg [NUM_LINES];
    logic signed [COORD_W-1:0] lx1_reg [NUM_LINES];
    logic signed [COORD_W-1:0] ly1_reg [NUM_LINES];
    logic signed [DL_W-1:0]    ldx_reg [NUM_LINES];
    logic signed [DL_W-1:0]    ldy_reg [NUM_LINES];
    logic signed [CL_W-1:0]    lc_reg  [NUM_LINES];
    logic [FIX_W-1:0]          px_reg  [4];
    logic [FIX_W-1:0]          py_reg  [4];
    logic                      last_pend_reg;
    logic signed [DL_W-1:0]    adx_reg, ady_reg, bdx_reg, bdy_reg;
    logic signed [CL_W-1:0]    ac_reg, bc_reg;
    logic signed [PW-1:0]      t_reg;
    logic signed [D_W-1:0]     d_reg;
    logic signed [NX_W-1:0]    nx_reg, ny_reg;
    logic [FIX_W-1:0]          cx_reg;
    logic [FIX_W-1:0]          wx_reg, wy_reg, wdx_reg, wdy_reg;
    logic [SCORE_W-1:0]        sum_reg;
    logic [IDX_OUT_W-1:0]      out_index_reg;
    logic [SCORE_W-1:0]        out_score_reg;
    logic                      out_found_reg;

    // shared units
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [PW-1:0]   prod;
    unit_ctl_t              uctl;
    unit_sts_t              usts;
    logic [UW-1:0]          u_a;
    logic [UW-1:0]          u_res;

    qlss_mul #(.AW(MA_W), .BW(MB_W)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    qlss_iter_unit #(.UW(UW), .DIV_BITS(DIV_BITS), .SQ_BITS(SQ_BITS)) u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (uctl),
        .a      (u_a),
        .b      (d_reg[D_W-2:0]),
        .sts    (usts),
        .result (u_res)
    );

    // handshake and decode
    logic                   accept;
    logic                   cfg_wr;
    logic [1:0]             k_sel, i_sel, j_sel;
    logic signed [PW-1:0]   nx_ext, ny_ext;
    logic                   pair_adv, set_end, report_go;
    logic [2:0]             n_fin;
    logic [SCORE_W:0]       sum_wide;
    logic [SCORE_W-1:0]     sum_sat;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_HEIGHT) ? 32'(height_reg) : 32'(width_reg);
    assign k_sel     = idx_reg[1:0];
    assign i_sel     = pair_first(idx_reg);
    assign j_sel     = pair_second(idx_reg);
    assign nx_ext    = PW'(nx_reg);
    assign ny_ext    = PW'(ny_reg);
    assign report_go = (state_reg == ST_REPORT) && (!out_valid_reg || m_tready);

    // saturating distance sum
    assign sum_wide = {1'b0, sum_reg} + (SCORE_W + 1)'(u_res);
    assign sum_sat  = sum_wide[SCORE_W] ? '1 : sum_wide[SCORE_W-1:0];

    // pair rejection and completion
    always_comb
    begin
        pair_adv = 1'b0;
        if (state_reg == ST_PAIR)
        begin
            case (step_reg)
                4'd9:    pair_adv = (d_reg == '0);
                4'd10:   pair_adv = (nx_reg < 0) || (ny_reg < 0);
                4'd11:   pair_adv = (nx_ext > prod);
                4'd12:   pair_adv = (ny_ext > prod);
                4'd14:   pair_adv = usts.done;
                default: pair_adv = 1'b0;
            endcase
        end
    end

    // corner count, bumped when the second division of a kept pair ends
    assign n_fin   = n_reg + 3'((state_reg == ST_PAIR) && (step_reg == 4'd14) && usts.done);
    assign set_end = (pair_adv && (idx_reg == 3'(NUM_PAIRS - 1)) && (n_fin != 3'd4))
                  || ((state_reg == ST_DIST) && (step_reg == 4'd5) && usts.done
                      && (idx_reg == 3'(NUM_PAIRS - 1)));

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_COEF:
            begin
                if (step_reg == 4'd0)
                begin
                    mul_a = MA_W'(lx0_reg[k_sel]);
                    mul_b = MB_W'(ly1_reg[k_sel]);
                end
                else
                begin
                    mul_a = MA_W'(ly0_reg[k_sel]);
                    mul_b = MB_W'(lx1_reg[k_sel]);
                end
            end
            ST_PAIR:
            begin
                case (step_reg)
                    4'd2:    begin mul_a = MA_W'(adx_reg); mul_b = MB_W'(bdy_reg); end
                    4'd3:    begin mul_a = MA_W'(ady_reg); mul_b = MB_W'(bdx_reg); end
                    4'd4:    begin mul_a = MA_W'(ac_reg);  mul_b = MB_W'(bdx_reg); end
                    4'd5:    begin mul_a = MA_W'(bc_reg);  mul_b = MB_W'(adx_reg); end
                    4'd6:    begin mul_a = MA_W'(ac_reg);  mul_b = MB_W'(bdy_reg); end
                    4'd7:    begin mul_a = MA_W'(bc_reg);  mul_b = MB_W'(ady_reg); end
                    4'd10:   begin mul_a = d_reg; mul_b = MB_W'({1'b0, width_reg}); end
                    4'd11:   begin mul_a = d_reg; mul_b = MB_W'({1'b0, height_reg}); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_DIST:
            begin
                if (step_reg == 4'd2)
                begin
                    mul_a = MA_W'({1'b0, wdx_reg});
                    mul_b = MB_W'({1'b0, wdx_reg});
                end
                else
                begin
                    mul_a = MA_W'({1'b0, wdy_reg});
                    mul_b = MB_W'({1'b0, wdy_reg});
                end
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared unit requests
    always_comb
    begin
        uctl.start = 1'b0;
        uctl.op    = OP_DIV;
        u_a        = '0;
        if (state_reg == ST_PAIR)
        begin
            if (step_reg == 4'd12)
            begin
                uctl.start = !pair_adv;
                u_a        = UW'(nx_reg[NX_W-2:0]) << FRACTION_BITS;
            end
            else if (step_reg == 4'd13)
            begin
                uctl.start = usts.done;
                u_a        = UW'(ny_reg[NX_W-2:0]) << FRACTION_BITS;
            end
        end
        else if (state_reg == ST_DIST)
        begin
            uctl.op    = OP_SQRT;
            uctl.start = (step_reg == 4'd4);
            u_a        = UW'(t_reg + prod);
        end
    end

    // sequencer and run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            idx_reg       <= '0;
            pos_reg       <= '0;
            n_reg         <= '0;
            set_count_reg <= '0;
            top_index_reg <= '0;
            top_score_reg <= '0;
            any_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else
        begin
            // configuration writes
            if (cfg_wr)
            begin
                if (paddr[2] == REG_HEIGHT)
                    height_reg <= pwdata[DIM_W-1:0];
                else
                    width_reg <= pwdata[DIM_W-1:0];
            end

            if (m_tready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (pos_reg != 2'(NUM_LINES - 1))
                        begin
                            pos_reg <= s_tlast ? 2'd0 : pos_reg + 1'b1;
                            if (s_tlast)
                                state_reg <= ST_REPORT;
                        end
                        else
                        begin
                            pos_reg   <= '0;
                            state_reg <= ST_COEF;
                            step_reg  <= '0;
                            idx_reg   <= '0;
                        end
                    end
                end
                ST_COEF:
                begin
                    if (step_reg == 4'd2)
                    begin
                        step_reg <= '0;
                        if (idx_reg == 3'(NUM_LINES - 1))
                        begin
                            idx_reg   <= '0;
                            n_reg     <= '0;
                            state_reg <= ST_PAIR;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                ST_PAIR:
                begin
                    n_reg <= n_fin;
                    if (pair_adv)
                    begin
                        step_reg <= '0;
                        if (idx_reg == 3'(NUM_PAIRS - 1))
                        begin
                            idx_reg <= '0;
                            if (n_fin == 3'd4)
                                state_reg <= ST_DIST;
                        end
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                    else if ((step_reg != 4'd13 && step_reg != 4'd14) || usts.done)
                        step_reg <= step_reg + 1'b1;
                end
                ST_DIST:
                begin
                    if (step_reg == 4'd5)
                    begin
                        if (usts.done)
                        begin
                            step_reg <= '0;
                            if (idx_reg == 3'(NUM_PAIRS - 1))
                            begin
                                any_found_reg <= 1'b1;
                                if (sum_sat > top_score_reg)
                                begin
                                    top_score_reg <= sum_sat;
                                    top_index_reg <= set_count_reg;
                                end
                            end
                            else
                                idx_reg <= idx_reg + 1'b1;
                        end
                    end
                    else
                        step_reg <= step_reg + 1'b1;
                end
                ST_REPORT:
                begin
                    if (report_go)
                    begin
                        out_valid_reg <= 1'b1;
                        pos_reg       <= '0;
                        set_count_reg <= '0;
                        top_score_reg <= '0;
                        top_index_reg <= '0;
                        any_found_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase

            // close a set
            if (set_end)
            begin
                set_count_reg <= set_count_reg + 1'b1;
                state_reg     <= last_pend_reg ? ST_REPORT : ST_IDLE;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lx0_reg[pos_reg] <= s_tdata[15:0];
            ly0_reg[pos_reg] <= s_tdata[31:16];
            lx1_reg[pos_reg] <= s_tdata[47:32];
            ly1_reg[pos_reg] <= s_tdata[63:48];
            last_pend_reg    <= s_tlast;
        end

        case (state_reg)
            ST_COEF:
            begin
                sum_reg <= '0;
                if (step_reg == 4'd0)
                begin
                    ldx_reg[k_sel] <= DL_W'(lx0_reg[k_sel]) - DL_W'(lx1_reg[k_sel]);
                    ldy_reg[k_sel] <= DL_W'(ly0_reg[k_sel]) - DL_W'(ly1_reg[k_sel]);
                end
                if (step_reg == 4'd1)
                    t_reg <= prod;
                if (step_reg == 4'd2)
                    lc_reg[k_sel] <= CL_W'(t_reg - prod);
            end
            ST_PAIR:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        adx_reg <= ldx_reg[i_sel];
                        ady_reg <= ldy_reg[i_sel];
                        ac_reg  <= lc_reg[i_sel];
                    end
                    4'd1:
                    begin
                        bdx_reg <= ldx_reg[j_sel];
                        bdy_reg <= ldy_reg[j_sel];
                        bc_reg  <= lc_reg[j_sel];
                    end
                    4'd3, 4'd5, 4'd7:
                        t_reg <= prod;
                    4'd4:
                        d_reg <= D_W'(t_reg - prod);
                    4'd6:
                        nx_reg <= NX_W'(t_reg - prod);
                    4'd8:
                        ny_reg <= NX_W'(t_reg - prod);
                    4'd9:
                    begin
                        if (d_reg < 0)
                        begin
                            d_reg  <= -d_reg;
                            nx_reg <= -nx_reg;
                            ny_reg <= -ny_reg;
                        end
                    end
                    4'd13:
                    begin
                        if (usts.done)
                            cx_reg <= u_res[FIX_W-1:0];
                    end
                    4'd14:
                    begin
                        if (usts.done && n_reg < 3'd4)
                        begin
                            px_reg[n_reg[1:0]] <= cx_reg;
                            py_reg[n_reg[1:0]] <= u_res[FIX_W-1:0];
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_DIST:
            begin
                case (step_reg)
                    4'd0:
                    begin
                        wx_reg <= px_reg[i_sel];
                        wy_reg <= py_reg[i_sel];
                    end
                    4'd1:
                    begin
                        wdx_reg <= (wx_reg > px_reg[j_sel]) ? wx_reg - px_reg[j_sel]
                                                             : px_reg[j_sel] - wx_reg;
                        wdy_reg <= (wy_reg > py_reg[j_sel]) ? wy_reg - py_reg[j_sel]
                                                             : py_reg[j_sel] - wy_reg;
                    end
                    4'd3:
                        t_reg <= prod;
                    4'd5:
                    begin
                        if (usts.done)
                            sum_reg <= sum_sat;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        // result register
        if (report_go)
        begin
            out_index_reg <= any_found_reg ? IDX_OUT_W'(top_index_reg) : '0;
            out_score_reg <= any_found_reg ? top_score_reg : '0;
            out_found_reg <= any_found_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_score_reg, out_index_reg};
    assign m_tuser  = out_found_reg;

endmodule

// ----- verif/quad_line_set_selector_chk.sv -----
// ----------------------------------------------------------------------------
// quad_line_set_selector_chk
// Watches the line, result and register channels of the set selector, keeps
// its own model of the corner search, and compares every result item.
// ----------------------------------------------------------------------------
module quad_line_set_selector_chk
    import qlss_pkg::*;
#(
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // start_x, start_y, end_x, end_y
    input  logic        s_tlast,   // last_of_all
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // best_index, best_score
    input  logic        m_tuser,   // found
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          lines_taken,
    output int          winners_seen,
    output int          winners_pending,
    output int          mismatches
);

    typedef struct {
        logic [IDX_OUT_W-1:0] index;
        logic [SCORE_W-1:0]   score;
        logic                 found;
    } winner_t;

    winner_t                 winner_q[$];
    logic [DIM_W-1:0]        img_w, img_h;
    logic [63:0]             set_lines[NUM_LINES];
    logic [1:0]              line_pos;
    logic [IDX_OUT_W-1:0]    set_num, top_idx;
    longint unsigned         top_sum;
    logic                    any_quad;

    // signed coordinate k of a packed line
    function automatic longint coord(input logic [63:0] w, input int k);
        return longint'($signed(w[16*k +: 16]));
    endfunction

    // floor(n/d) with FRACTION_BITS fraction bits, n >= 0, d > 0
    function automatic longint unsigned fixq(input longint n, input longint d);
        longint unsigned q, r;
        q = longint'(n) / d;
        r = longint'(n) % d;
        return (q << FRACTION_BITS) + ((r << FRACTION_BITS) / d);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // intersection of two lines; 1 when it exists and lies in the image
    function automatic bit corner_of(input logic [63:0] la, input logic [63:0] lb,
                                     output longint unsigned cx,
                                     output longint unsigned cy);
        longint dxa, dya, dxb, dyb, d, ca, cb, nx, ny;
        cx = 0;
        cy = 0;
        dxa = coord(la, 0) - coord(la, 2);
        dya = coord(la, 1) - coord(la, 3);
        dxb = coord(lb, 0) - coord(lb, 2);
        dyb = coord(lb, 1) - coord(lb, 3);
        d = dxa * dyb - dya * dxb;
        if (d == 0)
            return 0;
        ca = coord(la, 0) * coord(la, 3) - coord(la, 1) * coord(la, 2);
        cb = coord(lb, 0) * coord(lb, 3) - coord(lb, 1) * coord(lb, 2);
        nx = ca * dxb - dxa * cb;
        ny = ca * dyb - dya * cb;
        if (d < 0)
        begin
            d = -d;
            nx = -nx;
            ny = -ny;
        end
        if (nx < 0 || ny < 0)
            return 0;
        if (nx > longint'(img_w) * d || ny > longint'(img_h) * d)
            return 0;
        cx = fixq(nx, d);
        cy = fixq(ny, d);
        return 1;
    endfunction

    // score one complete set and update the running best
    task automatic score_set();
        longint unsigned px[6], py[6], sum, dx, dy, tx, ty;
        int n;
        n = 0;
        sum = 0;
        for (int i = 0; i < NUM_LINES; i++)
            for (int j = i + 1; j < NUM_LINES; j++)
                if (n < 6 && corner_of(set_lines[i], set_lines[j], tx, ty))
                begin
                    px[n] = tx;
                    py[n] = ty;
                    n++;
                end
        if (n == 4)
        begin
            for (int i = 0; i < 4; i++)
                for (int j = i + 1; j < 4; j++)
                begin
                    dx = (px[i] > px[j]) ? px[i] - px[j] : px[j] - px[i];
                    dy = (py[i] > py[j]) ? py[i] - py[j] : py[j] - py[i];
                    sum = sum + int_sqrt(dx * dx + dy * dy);
                    if (sum > 64'hFFFF_FFFF)
                        sum = 64'hFFFF_FFFF;
                end
            any_quad = 1'b1;
            if (sum > top_sum)
            begin
                top_sum = sum;
                top_idx = set_num;
            end
        end
        set_num = set_num + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        winner_t exp_w;
        if (!rst_n)
        begin
            img_w = WIDTH_RESET;
            img_h = HEIGHT_RESET;
            line_pos = 0;
            set_num = 0;
            top_idx = 0;
            top_sum = 0;
            any_quad = 0;
            lines_taken <= 0;
            winners_seen <= 0;
            winners_pending <= 0;
            mismatches <= 0;
            winner_q.delete();
        end
        else
        begin
            // register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_WIDTH)
                    img_w = pwdata[DIM_W-1:0];
                else
                    img_h = pwdata[DIM_W-1:0];
            end
            // line items
            if (s_tvalid && s_tready)
            begin
                lines_taken <= lines_taken + 1;
                set_lines[line_pos] = s_tdata;
                if (line_pos == 2'd3)
                begin
                    score_set();
                    line_pos = 0;
                end
                else
                    line_pos = line_pos + 1'b1;
                if (s_tlast)
                begin
                    exp_w.index = any_quad ? top_idx : '0;
                    exp_w.score = any_quad ? top_sum[SCORE_W-1:0] : '0;
                    exp_w.found = any_quad;
                    winner_q.insert(winner_q.size(), exp_w);
                    line_pos = 0;
                    set_num = 0;
                    top_idx = 0;
                    top_sum = 0;
                    any_quad = 0;
                end
            end
            // result items
            if (m_tvalid && m_tready)
            begin
                winners_seen <= winners_seen + 1;
                if (winner_q.size() == 0)
                begin
                    $error("unexpected result item: index %0d score %0d found %0d",
                           m_tdata[15:0], m_tdata[47:16], m_tuser);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    exp_w = winner_q.pop_front();
                    if (m_tdata[15:0] !== exp_w.index || m_tdata[47:16] !== exp_w.score ||
                        m_tuser !== exp_w.found)
                        mismatches <= mismatches + 1;
                    if (m_tdata[15:0] !== exp_w.index)
                        $error("best_index: expected %0d, got %0d", exp_w.index,
                               m_tdata[15:0]);
                    if (m_tdata[47:16] !== exp_w.score)
                        $error("best_score: expected %0d, got %0d", exp_w.score,
                               m_tdata[47:16]);
                    if (m_tuser !== exp_w.found)
                        $error("found: expected %0d, got %0d", exp_w.found, m_tuser);
                end
            end
            winners_pending <= winner_q.size();
        end
    end

endmodule

// ----- verif/quad_line_set_selector_tb.sv -----
// ----------------------------------------------------------------------------
// quad_line_set_selector_tb
// Drives line sets and register writes into the set selector and gives the
// verdict; prediction and comparison live in quad_line_set_selector_chk.
// ----------------------------------------------------------------------------
// A short directed part covers coordinate extremes, ties, zero-score sets,
// sets with no corners and runs cut off mid-set. Random phases then send
// mostly closed quadrilaterals inside the image plus random noise lines,
// under several image sizes and idling patterns, with one long result stall.
module quad_line_set_selector_tb;
    import qlss_pkg::*;

    localparam int WATCHDOG   = 20000;
    localparam int DRAIN_WAIT = 800;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_LINES = 128;

    logic        clk, rst_n;
    logic        s_tvalid, s_tready, s_tlast;
    logic [63:0] s_tdata;
    logic        m_tvalid, m_tready, m_tuser;
    logic [47:0] m_tdata;
    logic        psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    int lines_taken, winners_seen, winners_pending, mismatches;
    int send_idle_pct, recv_stall_pct, hold_left, quiet_cycles;
    int cur_w, cur_h;

    quad_line_set_selector i_dut (.*);

    quad_line_set_selector_chk i_chk (.*);

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // result side: random stalls, long hold-off when requested
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog: cycles with no accepted item of any kind
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG)
        begin
            $display("timeout: no activity for %0d cycles", WATCHDOG);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one line and wait until it is taken; valid drops at the next
    // idle cycle or when the stream pauses
    task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                             input bit last);
        int taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        taken = lines_taken;
        s_tvalid <= 1'b1;
        s_tdata  <= {ey[15:0], ex[15:0], sy[15:0], sx[15:0]};
        s_tlast  <= last;
        do
            @(negedge clk);
        while (lines_taken == taken);
    endtask

    // wait for every result, then let the block settle before a write
    task automatic drain();
        s_tvalid <= 1'b0;
        while (winners_pending != 0 || (s_tvalid && !s_tready))
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic reg_write(input logic addr_bit, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {addr_bit, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr_bit == REG_WIDTH)
            cur_w = value;
        else
            cur_h = value;
    endtask

    // quadrilateral with corners inside the image, edges as the four lines
    task automatic send_quad(input bit last);
        int qx[4], qy[4];
        for (int k = 0; k < 4; k++)
        begin
            qx[k] = $urandom_range(0, cur_w);
            qy[k] = $urandom_range(0, cur_h);
        end
        for (int k = 0; k < 4; k++)
            send_line(qx[k], qy[k], qx[(k + 1) % 4], qy[(k + 1) % 4], last && k == 3);
    endtask

    task automatic send_noise(input bit last);
        send_line($urandom, $urandom, $urandom, $urandom, last);
    endtask

    initial
    begin
        int lines_sent, sets_left, wsel;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_w = WIDTH_RESET;
        cur_h = HEIGHT_RESET;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: rectangle twice (tie keeps the first), zero-score set
        send_line(10, 10, 700, 10, 0);
        send_line(700, 10, 700, 150, 0);
        send_line(700, 150, 10, 150, 0);
        send_line(10, 150, 10, 10, 0);
        send_line(0, 5, 100, 5, 0);
        send_line(0, 5, 100, 5, 0);
        send_line(50, 0, 50, 100, 0);
        send_line(50, 0, 50, 100, 0);
        send_line(10, 10, 700, 10, 0);
        send_line(700, 10, 700, 150, 0);
        send_line(700, 150, 10, 150, 0);
        send_line(10, 150, 10, 10, 0);
        // coordinate extremes, closing the run
        send_line(-32768, -32768, 32767, 32767, 0);
        send_line(32767, -32768, -32768, 32767, 0);
        send_line(-32768, 32767, 32767, -32768, 0);
        send_line(0, 0, 0, 0, 1);
        // all parallel: nothing qualifies
        send_line(0, 1, 9, 1, 0);
        send_line(0, 2, 9, 2, 0);
        send_line(0, 3, 9, 3, 0);
        send_line(0, 4, 9, 4, 1);
        // run cut off mid-set
        send_line(5, 5, 50, 5, 0);
        send_line(5, 5, 5, 50, 1);

        // random phases with different image sizes and idling
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            case (ph)
                0: wsel = 4095;
                1: wsel = 1;
                2: wsel = 720;
                default: wsel = $urandom_range(1, 4095);
            endcase
            reg_write(REG_WIDTH, wsel);
            case (ph)
                0: wsel = 4095;
                1: wsel = 1;
                2: wsel = 4095;
                default: wsel = $urandom_range(1, 4095);
            endcase
            reg_write(REG_HEIGHT, wsel);
            send_idle_pct  = (ph % 4 == 1) ? 64 : (ph % 4 == 3) ? 22 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 64 : (ph % 4 == 3) ? 22 : 0;
            if (ph == 4)
                hold_left = 3000;
            lines_sent = 0;
            while (lines_sent < PHASE_LINES)
            begin
                sets_left = $urandom_range(1, 8);
                while (sets_left > 0)
                begin
                    sets_left--;
                    if ($urandom_range(0, 99) < 80)
                        send_quad(sets_left == 0);
                    else
                        for (int k = 0; k < 4; k++)
                            send_noise(sets_left == 0 && k == 3);
                    lines_sent += 4;
                end
                // occasionally close a run with a partial set
                if ($urandom_range(0, 99) < 10)
                begin
                    send_noise(0);
                    send_noise(1);
                    lines_sent += 2;
                end
            end
        end

        drain();
        $display("covered %0d line items and %0d result items across %0d image sizes",
                 lines_taken, winners_seen, NUM_PHASES + 1);
        $display("idling phases: none, sender, receiver, both; one long result stall");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/qlss_pkg.sv
design/qlss_mul.sv
design/qlss_iter_unit.sv
design/quad_line_set_selector.sv
verif/quad_line_set_selector_chk.sv
verif/quad_line_set_selector_tb.sv
